// File: rtl/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg: shared types and constants of the sorted list engine
// Holds the list depth, the data type, the operation and status codes and
// the control word that the top level broadcasts to every list cell.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 32;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0] count_t;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_APPEND,
    CMD_INSERT,
    CMD_DELETE,
    CMD_ROTATE
  } cmd_e;

  typedef struct packed {
    cmd_e  cmd;
    data_t value;
  } cell_ctl_t;

endpackage

// File: rtl/sle_cell.sv
// ----------------------------------------------------------------------------
// sle_cell: one slot of the sorted list
// Holds one entry and decides its next value from its own compare, from the
// position flag that ripples in from the head side, and from its neighbors.
// ----------------------------------------------------------------------------
module sle_cell (
  input  logic               clk_i,
  input  sle_pkg::cell_ctl_t ctl_i,
  input  logic               valid_i,
  input  logic               next_valid_i,
  input  sle_pkg::data_t     left_i,
  input  sle_pkg::data_t     right_i,
  input  sle_pkg::data_t     head_i,
  input  logic               hit_i,
  output logic               hit_o,
  output sle_pkg::data_t     q_o
);
  import sle_pkg::*;

  data_t entry_q, entry_d;
  logic  flag;

  always_comb begin
    flag    = 1'b0;
    entry_d = entry_q;
    case (ctl_i.cmd)
      CMD_APPEND, CMD_INSERT: begin
        // The new value lands in the first cell that is free or, for a
        // sorted insert, holds an entry that is not smaller; later cells
        // take their left neighbor.
        flag = !valid_i ||
               ((ctl_i.cmd == CMD_INSERT) && !(entry_q < ctl_i.value));
        if (hit_i) begin
          entry_d = left_i;
        end else if (flag) begin
          entry_d = ctl_i.value;
        end
      end
      CMD_DELETE: begin
        flag = valid_i && (entry_q == ctl_i.value);
        if (hit_i || flag) begin
          entry_d = right_i;
        end
      end
      CMD_ROTATE: begin
        // The valid part of the list turns one place toward the head, and
        // the head entry wraps around to the tail.
        if (next_valid_i) begin
          entry_d = right_i;
        end else if (valid_i) begin
          entry_d = head_i;
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  assign hit_o = hit_i || flag;
  assign q_o   = entry_q;

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// File: rtl/sorted_list_engine_unit.sv
// ----------------------------------------------------------------------------
// sorted_list_engine_unit: ordered list of signed Q16.16 values
// Append, sorted insert and delete work on a row of list cells and give one
// result beat in the cycle after the command is taken. A readout streams every entry from
// the head, one beat per cycle, with the last beat marked.
// ----------------------------------------------------------------------------
// An append, insert or delete is taken while idle; busy stays low and a
// new command may follow in the next cycle, its result beat appearing in the
// cycle after it is taken. A readout of N entries holds busy high while the
// cell row rotates the list past the head cell, giving one beat per cycle;
// an empty readout gives a single beat. Every result beat is on the outputs
// for one cycle only, marked by valid_o, and cannot be held.
module sorted_list_engine_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            op_i,
  input  logic signed [31:0]    value_i,
  output logic                  valid_o,
  output logic signed [31:0]    item_value_o,
  output logic                  last_o,
  output logic [1:0]            status_o,
  output logic [sle_pkg::CNT_W-1:0] entry_count_o
);
  import sle_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  state_e    state_q, state_d;
  count_t    count_q, count_d;
  count_t    rem_q, rem_d;
  logic      valid_q, valid_d;
  data_t     item_q, item_d;
  logic      last_q, last_d;
  status_e   status_q, status_d;
  cell_ctl_t ctl;
  op_e       op;
  logic      accept;
  logic      full;

  logic [DEPTH-1:0] cell_valid;
  logic [DEPTH:0]   hit;
  data_t            cell_q [DEPTH];

  assign op     = op_e'(op_i);
  assign accept = start && (state_q == S_IDLE);
  assign full   = (count_q == count_t'(DEPTH));

  assign hit[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    data_t left, right;
    logic  next_valid;

    assign cell_valid[i] = (count_q > count_t'(i));

    if (i == 0) begin : g_head
      assign left = '0;
    end else begin : g_body
      assign left = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right      = '0;
      assign next_valid = 1'b0;
    end else begin : g_inner
      assign right      = cell_q[i+1];
      assign next_valid = (count_q > count_t'(i + 1));
    end

    sle_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .valid_i     (cell_valid[i]),
      .next_valid_i(next_valid),
      .left_i      (left),
      .right_i     (right),
      .head_i      (cell_q[0]),
      .hit_i       (hit[i]),
      .hit_o       (hit[i+1]),
      .q_o         (cell_q[i])
    );
  end

  // The cell command depends only on registered state and the inputs, never
  // on the hit chain that the cells return.
  always_comb begin
    ctl.cmd   = CMD_HOLD;
    ctl.value = value_i;
    if (state_q == S_READ) begin
      ctl.cmd = CMD_ROTATE;
    end else if (accept) begin
      case (op)
        OP_APPEND, OP_INSERT: begin
          if (!full) begin
            ctl.cmd = (op == OP_INSERT) ? CMD_INSERT : CMD_APPEND;
          end
        end
        OP_DELETE: begin
          ctl.cmd = CMD_DELETE;
        end
        default: begin
          ctl.cmd = CMD_HOLD;
        end
      endcase
    end
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    rem_d     = rem_q;
    valid_d   = 1'b0;
    item_d    = '0;
    last_d    = 1'b1;
    status_d  = ST_OK;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          valid_d = 1'b1;
          case (op)
            OP_APPEND, OP_INSERT: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                count_d = count_q + count_t'(1);
              end
            end
            OP_DELETE: begin
              if (hit[DEPTH]) begin
                count_d = count_q - count_t'(1);
              end else begin
                status_d = ST_MISSING;
              end
            end
            OP_READ: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                valid_d = 1'b0;
                rem_d   = count_q;
                state_d = S_READ;
              end
            end
            default: begin
              valid_d = 1'b0;
            end
          endcase
        end
      end
      S_READ: begin
        // Each cycle the head entry goes out and the list turns by one, so
        // after the last beat the list is back in its original order.
        valid_d = 1'b1;
        item_d  = cell_q[0];
        last_d  = (rem_q == count_t'(1));
        rem_d   = rem_q - count_t'(1);
        if (last_d) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      rem_q    <= '0;
      valid_q  <= 1'b0;
      item_q   <= '0;
      last_q   <= 1'b0;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rem_q    <= rem_d;
      valid_q  <= valid_d;
      item_q   <= item_d;
      last_q   <= last_d;
      status_q <= status_d;
    end
  end

  assign busy          = (state_q == S_READ);
  assign valid_o       = valid_q;
  assign item_value_o  = item_q;
  assign last_o        = last_q;
  assign status_o      = status_q;
  assign entry_count_o = count_q;

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the sorted list engine
// Drives append, sorted insert, delete and readout commands, first a directed
// run over the corner cases, then random traffic in phases that grow and
// shrink the list under different amounts of sender idling. A scoreboard
// keeps its own copy of the list and checks every result beat in order.
// ----------------------------------------------------------------------------
module tb;
  import sle_pkg::*;

  typedef struct {
    data_t   value;
    logic    last;
    status_e status;
    count_t  count;
  } beat_t;

  // Tracks the list contents and the result beats each command must produce.
  class sorted_list_tracker;
    data_t       contents[DEPTH];
    int unsigned held;
    beat_t       pending[$];
    int unsigned errors;

    function new();
      held = 0;
      errors = 0;
    endfunction

    function void push_beat(data_t v, logic last, status_e st);
      beat_t b;
      b.value = v;
      b.last = last;
      b.status = st;
      b.count = count_t'(held);
      pending.push_back(b);
    endfunction

    function void note_command(op_e op, data_t v);
      int unsigned pos;
      int unsigned i;
      case (op)
        OP_APPEND, OP_INSERT: begin
          if (held >= DEPTH) begin
            push_beat('0, 1'b1, ST_FULL);
          end else begin
            pos = held;
            if (op == OP_INSERT) begin
              // Goes ahead of the first entry that is not smaller.
              pos = 0;
              while (pos < held && contents[pos] < v) pos++;
            end
            for (i = held; i > pos; i--) contents[i] = contents[i-1];
            contents[pos] = v;
            held++;
            push_beat('0, 1'b1, ST_OK);
          end
        end
        OP_DELETE: begin
          pos = 0;
          while (pos < held && contents[pos] != v) pos++;
          if (pos >= held) begin
            push_beat('0, 1'b1, ST_MISSING);
          end else begin
            for (i = pos; i + 1 < held; i++) contents[i] = contents[i+1];
            held--;
            push_beat('0, 1'b1, ST_OK);
          end
        end
        default: begin
          if (held == 0) begin
            push_beat('0, 1'b1, ST_EMPTY);
          end else begin
            for (i = 0; i < held; i++) push_beat(contents[i], i + 1 == held, ST_OK);
          end
        end
      endcase
    endfunction

    function void check_beat(data_t v, logic last, logic [1:0] st, count_t cnt);
      beat_t exp;
      if (pending.size() == 0) begin
        $error("result beat with no command waiting: item_value %0d", v);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (v !== exp.value) begin
        $error("item_value: expected %0d, got %0d", exp.value, v);
        errors++;
      end
      if (last !== exp.last) begin
        $error("last: expected %0d, got %0d", exp.last, last);
        errors++;
      end
      if (st !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, st);
        errors++;
      end
      if (cnt !== exp.count) begin
        $error("entry_count: expected %0d, got %0d", exp.count, cnt);
        errors++;
      end
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         start;
  logic         busy;
  logic [1:0]   op_i;
  data_t        value_i;
  logic         valid_o;
  data_t        item_value_o;
  logic         last_o;
  logic [1:0]   status_o;
  count_t       entry_count_o;

  sorted_list_tracker list_sb = new();

  data_t value_pool[8] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000,
                           32'shFFFF_FFFF, 32'sh0000_0001, 32'sh0001_0000,
                           32'shFFFF_0000, 32'sh0000_8000};

  sorted_list_engine_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .op_i          (op_i),
    .value_i       (value_i),
    .valid_o       (valid_o),
    .item_value_o  (item_value_o),
    .last_o        (last_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // A result beat seen at an edge always belongs to a command taken earlier,
  // so it is checked before the command taken at the same edge is noted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o === 1'b1)
        list_sb.check_beat(item_value_o, last_o, status_o, entry_count_o);
      if (start && busy === 1'b0)
        list_sb.note_command(op_e'(op_i), value_i);
    end
  end

  task automatic send_command(op_e op, data_t v);
    start <= 1'b1;
    op_i <= op;
    value_i <= v;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  task automatic sender_gap(int unsigned pct);
    if ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < pct) @(posedge clk_i);
    end
  endtask

  function automatic data_t pick_value();
    if ($urandom_range(0, 1) == 0) return value_pool[$urandom_range(0, 7)];
    return data_t'($urandom);
  endfunction

  function automatic data_t pick_victim();
    if (list_sb.held > 0 && $urandom_range(0, 99) < 70)
      return list_sb.contents[$urandom_range(0, list_sb.held - 1)];
    return pick_value();
  endfunction

  initial begin
    int unsigned idle_pct[4] = '{0, 66, 0, 20};
    int unsigned r;
    start = 1'b0;
    op_i = OP_APPEND;
    value_i = '0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty list cases, value extremes, then fill and overflow.
    send_command(OP_READ, 32'sh7FFF_FFFF);
    send_command(OP_DELETE, 32'sh0000_0000);
    send_command(OP_APPEND, 32'sh7FFF_FFFF);
    send_command(OP_APPEND, 32'sh8000_0000);
    send_command(OP_INSERT, 32'sh0000_0000);
    send_command(OP_INSERT, 32'sh8000_0000);
    send_command(OP_INSERT, 32'sh7FFF_FFFF);
    send_command(OP_READ, 32'sh8000_0000);
    send_command(OP_DELETE, 32'sh8000_0000);
    send_command(OP_DELETE, 32'sh1234_5678);
    send_command(OP_READ, 32'sh0000_0000);
    repeat (12) send_command(OP_APPEND, pick_value());
    send_command(OP_APPEND, 32'sh0000_0001);
    send_command(OP_INSERT, 32'sh8000_0000);
    send_command(OP_READ, '1);

    // Random: even phases grow the list toward full, odd phases drain it.
    for (int phase = 0; phase < 4; phase++) begin
      repeat (61) begin
        sender_gap(idle_pct[phase]);
        r = $urandom_range(0, 99);
        if (phase % 2 == 0) begin
          if (r < 40) send_command(OP_INSERT, pick_value());
          else if (r < 55) send_command(OP_APPEND, pick_value());
          else if (r < 80) send_command(OP_DELETE, pick_victim());
          else send_command(OP_READ, data_t'($urandom));
        end else begin
          if (r < 25) send_command(OP_INSERT, pick_value());
          else if (r < 35) send_command(OP_APPEND, pick_value());
          else if (r < 80) send_command(OP_DELETE, pick_victim());
          else send_command(OP_READ, data_t'($urandom));
        end
      end
    end
    start <= 1'b0;

    while (list_sb.pending.size() != 0 || busy !== 1'b0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (list_sb.errors == 0 && list_sb.pending.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #(20 * 200000);
    $display("tb failed");
    $finish;
  end

endmodule

// File: filelist.f
rtl/sle_pkg.sv
rtl/sle_cell.sv
rtl/sorted_list_engine_unit.sv
tb/tb.sv
